// ----- sv/bu2d_pkg.sv -----
// Package for the bilinear upsampler: payload types, config indexes, defaults.
// Used by bilinear_upsample_2d_top.
package bu2d_pkg;

  localparam int unsigned MaxHeightDef  = 64;
  localparam int unsigned MaxWidthDef   = 64;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned FracBits      = 17;

  typedef enum logic [2:0] {
    CfgInHeight = 3'd0,
    CfgInWidth  = 3'd1,
    CfgAlign    = 3'd2,
    CfgRowScale = 3'd3,
    CfgColScale = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ReqWrite  = 1'b0,
    ReqInterp = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    StIdle,
    StMap,
    StRead0,
    StRead1,
    StBlendW,
    StBlendH,
    StOut
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  src_row;
    logic [5:0]  src_col;
    logic signed [15:0] pixel_value;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [9:0]  res_row;
    logic [9:0]  res_col;
  } out_item_t;

endpackage

// ----- sv/bilinear_upsample_2d_top.sv -----
// Top level of the bilinear upsampler: pixel store, coordinate mapping, blend.
// Depends on bu2d_pkg.
//
// channel | direction | handshake       | payload
// in      | input     | in_valid/stall  | in_item_t
// out     | output    | out_valid/stall | out_item_t
// cfg     | input     | valid/ready     | index, data
//
// A write item is stored when it is accepted. An interpolate item goes through
// accept, map, upper-row read, lower-row read with the upper width blend, lower
// width blend, height blend, round into the output register, result.
// Reset presets control and config; the pixel store is undefined until written.
// An output stall holds the result; a new item is taken once it leaves.
module bilinear_upsample_2d_top
  import bu2d_pkg::*;
#(
  parameter int unsigned MAX_HEIGHT  = MaxHeightDef,
  parameter int unsigned MAX_WIDTH   = MaxWidthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [23:0]      cfg_data_i
);

  localparam int unsigned RowBits  = $clog2(MAX_HEIGHT);
  localparam int unsigned ColBits  = $clog2(MAX_WIDTH);
  localparam int unsigned AddrBits = RowBits + ColBits;
  localparam int unsigned Depth    = 1 << AddrBits;
  localparam int unsigned SrcBits  = 36;
  localparam int unsigned WBits    = SAMPLE_BITS + FracBits + 2;
  localparam int unsigned VBits    = WBits + FracBits + 2;
  localparam logic [FracBits:0] FracOne = (FracBits+1)'(1) << FracBits;

  logic [6:0]  in_height_q, in_width_q;
  logic        align_q;
  logic [23:0] row_scale_q, col_scale_q;

  state_e state_q, state_d;
  logic [9:0] orow_q, ocol_q;
  logic [RowBits-1:0] r0_q, r1_q;
  logic [ColBits-1:0] c0_q, c1_q;
  logic [FracBits-1:0] lh_q, lw_q;
  logic signed [WBits-1:0] top_q, bot_q;
  logic signed [VBits-1:0] v_q;
  out_item_t out_q;
  logic out_valid_q;

  logic [SAMPLE_BITS-1:0] mem_a [Depth];
  logic [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic [AddrBits-1:0] rd_a_addr, rd_b_addr;
  logic [AddrBits-1:0] wr_addr;
  logic wr_en;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q <= 7'd1;
      in_width_q  <= 7'd1;
      align_q     <= 1'b0;
      row_scale_q <= 24'd65536;
      col_scale_q <= 24'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgInHeight: in_height_q <= cfg_data_i[6:0];
        CfgInWidth:  in_width_q  <= cfg_data_i[6:0];
        CfgAlign:    align_q     <= cfg_data_i[0];
        CfgRowScale: row_scale_q <= cfg_data_i;
        CfgColScale: col_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sizes, minus one.
  function automatic logic [10:0] eff_m1(input logic [6:0] r, input int unsigned mx);
    logic [10:0] v;
    v = 11'(r);
    if (v == 11'd0) v = 11'd1;
    if (v > 11'(mx)) v = 11'(mx);
    return v - 11'd1;
  endfunction

  typedef struct packed {
    logic [10:0]         i0;
    logic [10:0]         i1;
    logic [FracBits-1:0] lam;
  } map_t;

  function automatic map_t map_coord(input logic [9:0] o, input logic [23:0] sc,
                                     input logic al, input logic [10:0] sm1);
    logic [SrcBits-1:0] t, src;
    logic [SrcBits-1:0] ip;
    map_t m;
    if (al) begin
      src = SrcBits'(sc) * SrcBits'({o, 1'b0});
    end else begin
      t   = SrcBits'(sc) * SrcBits'({o, 1'b1});
      src = (t > SrcBits'(65536)) ? t - SrcBits'(65536) : '0;
    end
    ip    = src >> FracBits;
    m.lam = src[FracBits-1:0];
    if (ip > SrcBits'(sm1)) ip = SrcBits'(sm1);
    m.i0 = ip[10:0];
    m.i1 = (ip + SrcBits'(1) < SrcBits'(sm1)) ? ip[10:0] + 11'd1 : sm1;
    return m;
  endfunction

  map_t mr, mc;
  assign mr = map_coord(orow_q, row_scale_q, align_q, eff_m1(in_height_q, MAX_HEIGHT));
  assign mc = map_coord(ocol_q, col_scale_q, align_q, eff_m1(in_width_q, MAX_WIDTH));

  always_comb begin
    rd_a_addr = {r0_q, c0_q};
    rd_b_addr = {r0_q, c1_q};
    if (state_q == StRead1) begin
      rd_a_addr = {r1_q, c0_q};
      rd_b_addr = {r1_q, c1_q};
    end
  end

  assign wr_addr = {RowBits'(in_data_i.src_row), ColBits'(in_data_i.src_col)};
  assign wr_en   = in_acc && (in_data_i.req_type == ReqWrite)
                && (32'(in_data_i.src_row) < MAX_HEIGHT)
                && (32'(in_data_i.src_col) < MAX_WIDTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[wr_addr] <= SAMPLE_BITS'($unsigned(in_data_i.pixel_value));
    end
    rd_a_q <= mem_a[rd_a_addr];
    rd_b_q <= mem_a[rd_b_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_acc && in_data_i.req_type == ReqInterp) state_d = StMap;
      StMap:    state_d = StRead0;
      StRead0:  state_d = StRead1;
      StRead1:  state_d = StBlendW;
      StBlendW: state_d = StBlendH;
      StBlendH: state_d = StOut;
      StOut:    state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  logic signed [WBits-1:0] blend_w;
  logic signed [VBits-1:0] blend_h;
  logic signed [VBits+1:0] rnd;
  logic signed [VBits+1:0] res;
  logic signed [SAMPLE_BITS-1:0] sat;
  localparam int unsigned Sh = 2 * FracBits;

  assign blend_w = WBits'($signed(rd_a_q)) * $signed(WBits'({1'b0, FracOne - (FracBits+1)'(lw_q)}))
                 + WBits'($signed(rd_b_q)) * $signed(WBits'({1'b0, lw_q}));
  assign blend_h = VBits'(top_q) * $signed(VBits'({1'b0, FracOne - (FracBits+1)'(lh_q)}))
                 + VBits'(bot_q) * $signed(VBits'({1'b0, lh_q}));
  assign rnd = (VBits+2)'(v_q) + ((VBits+2)'(1) <<< (Sh - 1));
  assign res = rnd >>> Sh;

  always_comb begin
    if (res > (VBits+2)'((64'sd1 <<< (SAMPLE_BITS-1)) - 1))
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else if (res < -((VBits+2)'(64'sd1 <<< (SAMPLE_BITS-1))))
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else
      sat = res[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut) out_valid_q <= 1'b1;
      else if (out_acc)     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      orow_q <= in_data_i.out_row;
      ocol_q <= in_data_i.out_col;
    end
    if (state_q == StMap) begin
      r0_q <= mr.i0[RowBits-1:0];
      r1_q <= mr.i1[RowBits-1:0];
      c0_q <= mc.i0[ColBits-1:0];
      c1_q <= mc.i1[ColBits-1:0];
      lh_q <= mr.lam;
      lw_q <= mc.lam;
    end
    if (state_q == StRead1)  top_q <= blend_w;
    if (state_q == StBlendW) bot_q <= blend_w;
    if (state_q == StBlendH) v_q   <= blend_h;
    if (state_q == StOut) begin
      out_q.sample  <= 16'(sat);
      out_q.res_row <= orow_q;
      out_q.res_col <= ocol_q;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_acc) else $error("item accepted while busy");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> out_valid_o) else $error("result lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && state_q != StIdle) |-> 1'b0) else $error("overlap of result and work");

endmodule

// ----- test/tb.sv -----
// Testbench for bilinear_upsample_2d_top: directed and random pixel writes and
// interpolation requests checked against an in-bench fixed-point bilinear predictor.
// Depends on bu2d_pkg and bilinear_upsample_2d_top.
`timescale 1ns / 1ps

module tb;
  import bu2d_pkg::*;

  localparam int unsigned StoreRows = 64;
  localparam int unsigned StoreCols = 64;
  localparam int unsigned FracW = 17;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldOff = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  bilinear_upsample_2d_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic signed [15:0] pix_mem [StoreRows*StoreCols];
  bit pix_written [StoreRows*StoreCols];
  logic [6:0] height_q, width_q;
  logic align_q;
  logic [23:0] rscale_q, cscale_q;

  out_item_t sample_queue[$];
  int unsigned err_cnt = 0;
  int unsigned src_idle = 8, snk_idle = 69;
  int unsigned hold_cnt = 0;
  int unsigned idle_cycles = 0;
  bit out_hit, in_hit, cfg_hit;
  out_item_t out_seen;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic int unsigned plane_size(input logic [6:0] reg_val, input int unsigned maxv);
    if (reg_val == 0) return 1;
    if (reg_val > maxv) return maxv;
    return reg_val;
  endfunction

  function automatic void map_axis(input logic [9:0] o, input logic [23:0] scale,
                                   input int unsigned size, output int unsigned lo,
                                   output int unsigned hi, output longint lam);
    longint unsigned src, t, ip;
    if (align_q) begin
      src = longint'(scale) * o * 2;
    end else begin
      t = longint'(scale) * (2 * longint'(o) + 1);
      src = (t > 65536) ? t - 65536 : 0;
    end
    ip = src >> FracW;
    lam = src & ((64'd1 << FracW) - 1);
    if (ip > size - 1) ip = size - 1;
    lo = 32'(ip);
    hi = (ip + 1 < size - 1) ? 32'(ip + 1) : size - 1;
  endfunction

  function automatic out_item_t blend_sample(input in_item_t it);
    int unsigned r0, r1, c0, c1;
    longint lh, lw, top, bot, v, res, one;
    out_item_t o;
    one = 64'sd1 <<< FracW;
    map_axis(it.out_row, rscale_q, plane_size(height_q, StoreRows), r0, r1, lh);
    map_axis(it.out_col, cscale_q, plane_size(width_q, StoreCols), c0, c1, lw);
    top = longint'(pix_mem[r0*StoreCols+c0]) * (one - lw)
        + longint'(pix_mem[r0*StoreCols+c1]) * lw;
    bot = longint'(pix_mem[r1*StoreCols+c0]) * (one - lw)
        + longint'(pix_mem[r1*StoreCols+c1]) * lw;
    v = top * (one - lh) + bot * lh;
    res = (v + (64'sd1 <<< (2*FracW-1))) >>> (2*FracW);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    o.sample = res[15:0];
    o.res_row = it.out_row;
    o.res_col = it.out_col;
    return o;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    if (it.req_type == ReqInterp) begin
      sample_queue = {sample_queue, blend_sample(it)};
    end else begin
      pix_mem[it.src_row*StoreCols+it.src_col] = it.pixel_value;
      pix_written[it.src_row*StoreCols+it.src_col] = 1'b1;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      CfgInHeight: height_q = val[6:0];
      CfgInWidth:  width_q = val[6:0];
      CfgAlign:    align_q = val[0];
      CfgRowScale: rscale_q = val;
      CfgColScale: cscale_q = val;
      default: ;
    endcase
  endtask

  task automatic set_plane(input logic [6:0] h, input logic [6:0] w, input logic al,
                           input logic [23:0] rs, input logic [23:0] cs);
    drain();
    write_cfg(CfgInHeight, h);
    write_cfg(CfgInWidth, w);
    write_cfg(CfgAlign, al);
    write_cfg(CfgRowScale, rs);
    write_cfg(CfgColScale, cs);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t rand_item(input logic kind);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    it.req_type = kind;
    return it;
  endfunction

  task automatic put_pixel(input int r, input int c, input logic signed [15:0] val);
    in_item_t it;
    it = rand_item(ReqWrite);
    it.src_row = 6'(r);
    it.src_col = 6'(c);
    it.pixel_value = val;
    send_item(it);
  endtask

  task automatic ask(input logic [9:0] r, input logic [9:0] c);
    in_item_t it;
    it = rand_item(ReqInterp);
    it.out_row = r;
    it.out_col = c;
    send_item(it);
  endtask

  // Fill every entry of the active plane that has not been written yet.
  task automatic fill_plane();
    int unsigned h, w;
    h = plane_size(height_q, StoreRows);
    w = plane_size(width_q, StoreCols);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (!pix_written[r*StoreCols+c]) put_pixel(r, c, $urandom);
  endtask

  task automatic test_reset_defaults();
    put_pixel(0, 0, 16'sh7fff);
    ask(0, 0);
    ask(10'h3ff, 10'h3ff);
    put_pixel(0, 0, 16'sh8000);
    ask(1, 2);
  endtask

  task automatic test_directed();
    set_plane(4, 4, 1'b1, 24'h010000 / 2, 24'h010000 / 3);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        put_pixel(r, c, (r + c) % 2 ? 16'sh7fff : 16'sh8000);
    ask(0, 0);
    ask(3, 5);
    ask(6, 9);
    ask(10'h3ff, 10'h3ff);
    set_plane(4, 4, 1'b0, 24'h008000, 24'h00c000);
    ask(0, 0);
    ask(3, 4);
    set_plane(0, 7'h7f, 1'b0, 24'h000000, 24'hffffff);
    fill_plane();
    ask(5, 1);
    ask(10'h3ff, 10'h200);
    set_plane(7'h7f, 1, 1'b1, 24'hffffff, 24'h000000);
    fill_plane();
    ask(0, 7);
    ask(10'h3ff, 0);
    put_pixel(63, 63, 16'sh1234);
  endtask

  task automatic test_random(input int unsigned n_interp);
    int unsigned done, h, w, mode;
    done = 0;
    while (done < n_interp) begin
      if ($urandom_range(9) == 0) begin
        h = $urandom_range(1) ? 64 : $urandom_range(1, 2);
        w = $urandom_range(1, 2);
        if ($urandom_range(1)) begin
          mode = h; h = w; w = mode;
        end
      end else begin
        h = $urandom_range(1, 8);
        w = $urandom_range(1, 8);
      end
      case ($urandom_range(3))
        0: set_plane(h, w, $urandom, $urandom, $urandom);
        1: set_plane(h, w, 1'b1, (h << 16) / $urandom_range(1, 4*h),
                     (w << 16) / $urandom_range(1, 4*w));
        default: set_plane(h, w, 1'b0, $urandom_range(16'h2000, 24'h020000),
                           $urandom_range(16'h2000, 24'h020000));
      endcase
      fill_plane();
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(4) == 0) begin
          if ($urandom_range(1)) put_pixel($urandom_range(h - 1), $urandom_range(w - 1), $urandom);
          else put_pixel($urandom_range(63), $urandom_range(63), $urandom);
        end else begin
          if ($urandom_range(3) == 0) ask($urandom, $urandom);
          else ask($urandom_range(4*h), $urandom_range(4*w));
          done++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_plane(3, 3, 1'b0, 24'h008000, 24'h008000);
    fill_plane();
    hold_cnt = HoldOff;
    for (int k = 0; k < 40; k++) ask($urandom_range(8), $urandom_range(8));
  endtask

  always @(negedge clk_i) begin
    out_hit = out_valid_o && !out_stall_i;
    out_seen = out_data_o;
    in_hit = in_valid_i && !in_stall_o;
    cfg_hit = cfg_valid_i && cfg_ready_o;
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < snk_idle);
    end
    if (rst_ni && out_hit) begin
      if (sample_queue.size() == 0) begin
        report_mismatch("unexpected result row", out_seen.res_row, -1);
      end else begin
        want = sample_queue.pop_front();
        if (out_seen.sample !== want.sample)
          report_mismatch("sample", out_seen.sample, want.sample);
        if (out_seen.res_row !== want.res_row)
          report_mismatch("res_row", out_seen.res_row, want.res_row);
        if (out_seen.res_col !== want.res_col)
          report_mismatch("res_col", out_seen.res_col, want.res_col);
      end
    end
    if (rst_ni && !(out_hit || in_hit || cfg_hit)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    pix_mem = '{default: '0};
    pix_written = '{default: 1'b0};
    height_q = 1;
    width_q = 1;
    align_q = 1'b0;
    rscale_q = 24'h010000;
    cscale_q = 24'h010000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random(200);
    src_idle = 69;
    snk_idle = 8;
    test_random(200);
    src_idle = 0;
    snk_idle = 0;
    test_random(200);
    test_backpressure();
    drain();
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
